>>> design/imit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imit_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 4;
   localparam int CNT_OUT_W   = 5;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 72;  // start, end, index, padded to bytes
   localparam int RSP_TDATA_W = 72;  // count, start, end, padded to bytes

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_COLLAPSE,
      ST_DONE
   } imit_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_MERGE,
      CELL_LEFT,
      CELL_RIGHT
   } imit_cell_op_type;

   typedef struct packed {
      imit_cell_op_type op;
      logic             valid;   // cell lies below the entry count
   } imit_cell_ctl_type;

endpackage

`default_nettype wire

>>> design/imit_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table slot: holds an interval, compares it with the key, and loads
// from the merged value or a neighbor.
module imit_cell (
   input  wire                                  clock,
   input  imit_pkg::imit_cell_ctl_type          ctl,
   input  wire logic signed [imit_pkg::DATA_W-1:0] key_start,
   input  wire logic signed [imit_pkg::DATA_W-1:0] key_end,
   input  wire logic signed [imit_pkg::DATA_W-1:0] merged_start,
   input  wire logic signed [imit_pkg::DATA_W-1:0] merged_end,
   input  wire logic signed [imit_pkg::DATA_W-1:0] left_start,
   input  wire logic signed [imit_pkg::DATA_W-1:0] left_end,
   input  wire logic signed [imit_pkg::DATA_W-1:0] right_start,
   input  wire logic signed [imit_pkg::DATA_W-1:0] right_end,
   output logic signed [imit_pkg::DATA_W-1:0]      cell_start,
   output logic signed [imit_pkg::DATA_W-1:0]      cell_end,
   output logic                                    reach_ge,
   output logic                                    beyond_gt
);

   logic signed [imit_pkg::DATA_W-1:0] start_ff, start_in;
   logic signed [imit_pkg::DATA_W-1:0] end_ff, end_in;

   always_comb begin
      unique case (ctl.op)
         imit_pkg::CELL_HOLD: begin
            start_in = start_ff;
            end_in   = end_ff;
         end
         imit_pkg::CELL_MERGE: begin
            start_in = merged_start;
            end_in   = merged_end;
         end
         imit_pkg::CELL_LEFT: begin
            start_in = left_start;
            end_in   = left_end;
         end
         imit_pkg::CELL_RIGHT: begin
            start_in = right_start;
            end_in   = right_end;
         end
         default: begin
            start_in = start_ff;
            end_in   = end_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign cell_start = start_ff;
   assign cell_end   = end_ff;
   // entry reaches the new start / lies past the new end
   assign reach_ge   = ctl.valid && (end_ff >= key_start);
   assign beyond_gt  = ctl.valid && (start_ff > key_end);

endmodule

`default_nettype wire

>>> design/interval_merge_insert_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata (low bit up)                        | tuser
// req_    | in  | range_start[31:0] range_end[63:32]        | command
//         |     | read_index[67:64], zero pad to 72         |
// rsp_    | out | entry_count[4:0] entry_start[36:5]        | status
//         |     | entry_end[68:37], zero pad to 72          |
//
// A read or an insert that absorbs at most one entry goes from update to done;
// an insert that absorbs more entries passes through collapse, one left shift of
// the cell chain per step, until the gap is closed up.
// The compare runs in all cells in the accept cycle, the merge and shift in
// the next. Reset clears count and control; cell contents stay undefined.
// The next item is taken in the cycle the result enters the output register;
// a stalled output holds the block in its final state.
module interval_merge_insert_table #(
   parameter int CAPACITY = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [imit_pkg::REQ_TDATA_W-1:0]   req_tdata,  // range_start, range_end, read_index
   input  wire                               req_tuser,  // command
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [imit_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // entry_count, entry_start, entry_end
   output logic [imit_pkg::STATUS_W-1:0]     rsp_tuser   // status
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + imit_pkg::IDX_W;  // shared width for index compares
   localparam int DW = imit_pkg::DATA_W;

   imit_pkg::imit_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;

   // command captured on accept
   logic                 cmd_ff;
   logic signed [DW-1:0] key_start_ff, key_end_ff;
   logic [imit_pkg::IDX_W-1:0] idx_ff;
   logic signed [DW-1:0] req_start, req_end;

   // per-cell flags
   logic [CAPACITY-1:0] ge_ff, gt_ff, ge_now, gt_now;
   logic [CAPACITY-1:0] dead_ff, dead_in, tail_ff, tail_in;
   logic [CAPACITY-1:0] cell_valid, absorbed, first_abs, last_abs, after, after_first;
   logic [CAPACITY-1:0] seen_ge, stop_gt;  // run start reached / run end reached so far

   logic signed [DW-1:0] cell_start [CAPACITY];
   logic signed [DW-1:0] cell_end   [CAPACITY];
   imit_pkg::imit_cell_ctl_type cell_ctl [CAPACITY];

   logic signed [DW-1:0] sel_start, sel_end, rd_start, rd_end;
   logic signed [DW-1:0] merged_start, merged_end;
   logic any_abs, drop, rd_hit;

   // pending result
   logic signed [DW-1:0] res_start_ff, res_start_in, res_end_ff, res_end_in;
   logic [imit_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   // output register
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [imit_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [imit_pkg::STATUS_W-1:0]    rsp_tuser_ff, rsp_tuser_in;

   logic out_free, req_fire, out_load;

   assign req_start = req_tdata[DW-1:0];
   assign req_end   = req_tdata[2*DW-1:DW];
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_fire  = req_tvalid && req_tready;

   // ---------------- cell chain ----------------
   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         imit_cell u_cell (
            .clock        (clock),
            .ctl          (cell_ctl[k]),
            .key_start    (req_start),
            .key_end      (req_end),
            .merged_start (merged_start),
            .merged_end   (merged_end),
            .left_start   ((k == 0) ? cell_start[k] : cell_start[(k == 0) ? 0 : k-1]),
            .left_end     ((k == 0) ? cell_end[k]   : cell_end[(k == 0) ? 0 : k-1]),
            .right_start  ((k == CAPACITY-1) ? cell_start[k]
                                             : cell_start[(k == CAPACITY-1) ? k : k+1]),
            .right_end    ((k == CAPACITY-1) ? cell_end[k]
                                             : cell_end[(k == CAPACITY-1) ? k : k+1]),
            .cell_start   (cell_start[k]),
            .cell_end     (cell_end[k]),
            .reach_ge     (ge_now[k]),
            .beyond_gt    (gt_now[k])
         );
         assign cell_valid[k] = CW'(k) < count_ff;
      end
   endgenerate

   // ---------------- merge decode (from registered compare flags) ----------------
   // Run starts at the first entry reaching the new start and stops at the first entry
   // from there on past the new end; flags need not be monotone once a reversed
   // interval is stored, so both bounds are found by a prefix scan.
   always_comb begin
      sel_start = '0;
      sel_end   = '0;
      rd_start  = '0;
      rd_end    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            seen_ge[i] = ge_ff[i];
            stop_gt[i] = ge_ff[i] && gt_ff[i];
         end else begin
            seen_ge[i] = seen_ge[i-1] || ge_ff[i];
            stop_gt[i] = stop_gt[i-1] || (seen_ge[i] && gt_ff[i]);
         end
         absorbed[i] = seen_ge[i] && !stop_gt[i] && cell_valid[i];
         after[i]    = seen_ge[i] || !cell_valid[i];
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            first_abs[i]   = absorbed[i];
            after_first[i] = after[i];
         end else begin
            first_abs[i]   = absorbed[i] && !absorbed[i-1];
            after_first[i] = after[i] && !after[i-1];
         end
         if (i == CAPACITY-1) begin
            last_abs[i] = absorbed[i];
         end else begin
            last_abs[i] = absorbed[i] && !absorbed[i+1];
         end
         sel_start = sel_start | (cell_start[i] & {DW{first_abs[i]}});
         sel_end   = sel_end   | (cell_end[i]   & {DW{last_abs[i]}});
         if (XW'(idx_ff) == XW'(i)) begin
            rd_start = cell_start[i];
            rd_end   = cell_end[i];
         end
      end
      any_abs      = |absorbed;
      drop         = !any_abs && (count_ff == CW'(CAPACITY));
      rd_hit       = XW'(idx_ff) < XW'(count_ff);
      merged_start = (any_abs && (sel_start < key_start_ff)) ? sel_start : key_start_ff;
      merged_end   = (any_abs && (sel_end > key_end_ff))     ? sel_end   : key_end_ff;
   end

   // ---------------- per-cell control ----------------
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctl[i].valid = cell_valid[i];
         cell_ctl[i].op    = imit_pkg::CELL_HOLD;
         tail_in[i]        = tail_ff[i];
         dead_in[i]        = 1'b0;
         unique case (state_ff)
            imit_pkg::ST_UPDATE: begin
               tail_in[i] = after[i] && !first_abs[i];
               if (cmd_ff == imit_pkg::CMD_INSERT && !drop) begin
                  if (any_abs) begin
                     // first absorbed slot takes the merge, the rest die
                     if (first_abs[i]) begin
                        cell_ctl[i].op = imit_pkg::CELL_MERGE;
                     end
                     dead_in[i] = absorbed[i] && !first_abs[i];
                  end else if (after_first[i]) begin
                     cell_ctl[i].op = imit_pkg::CELL_MERGE;
                  end else if (after[i]) begin
                     cell_ctl[i].op = imit_pkg::CELL_LEFT;   // open a slot
                  end
               end
            end
            imit_pkg::ST_COLLAPSE: begin
               if (tail_ff[i]) begin
                  cell_ctl[i].op = imit_pkg::CELL_RIGHT;   // close up by one
                  dead_in[i]     = (i == CAPACITY-1) ? 1'b0
                                 : dead_ff[(i == CAPACITY-1) ? i : i+1];
               end
            end
            imit_pkg::ST_IDLE, imit_pkg::ST_DONE: begin
               cell_ctl[i].op = imit_pkg::CELL_HOLD;
            end
            default: begin
               cell_ctl[i].op = imit_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      unique case (state_ff)
         imit_pkg::ST_IDLE:     state_in = req_fire ? imit_pkg::ST_UPDATE : imit_pkg::ST_IDLE;
         imit_pkg::ST_UPDATE,
         imit_pkg::ST_COLLAPSE: state_in = (|dead_in) ? imit_pkg::ST_COLLAPSE
                                                      : imit_pkg::ST_DONE;
         imit_pkg::ST_DONE: begin
            if (req_fire) begin
               state_in = imit_pkg::ST_UPDATE;
            end else if (out_free) begin
               state_in = imit_pkg::ST_IDLE;
            end else begin
               state_in = imit_pkg::ST_DONE;
            end
         end
         default:               state_in = imit_pkg::ST_IDLE;
      endcase
   end

   // ---------------- FSM outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         imit_pkg::ST_IDLE: req_tready = 1'b1;
         imit_pkg::ST_DONE: begin
            out_load   = out_free;
            req_tready = out_free;
         end
         imit_pkg::ST_UPDATE, imit_pkg::ST_COLLAPSE: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   // ---------------- count and result ----------------
   always_comb begin
      count_in      = count_ff;
      res_start_in  = res_start_ff;
      res_end_in    = res_end_ff;
      res_status_in = res_status_ff;
      if (state_ff == imit_pkg::ST_UPDATE) begin
         res_status_in = imit_pkg::STATUS_OK;
         res_start_in  = '0;
         res_end_in    = '0;
         if (cmd_ff == imit_pkg::CMD_READ) begin
            if (rd_hit) begin
               res_start_in = rd_start;
               res_end_in   = rd_end;
            end else begin
               res_status_in = imit_pkg::STATUS_RANGE;
            end
         end else if (drop) begin
            res_status_in = imit_pkg::STATUS_FULL;
         end else begin
            res_start_in = merged_start;
            res_end_in   = merged_end;
            if (!any_abs) begin
               count_in = count_ff + CW'(1);
            end
         end
      end else if (state_ff == imit_pkg::ST_COLLAPSE) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{(imit_pkg::RSP_TDATA_W - 2*DW - imit_pkg::CNT_OUT_W){1'b0}},
                          res_end_ff, res_start_ff, imit_pkg::CNT_OUT_W'(count_ff)};
         rsp_tuser_in  = res_status_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= imit_pkg::ST_IDLE;
         count_ff      <= '0;
         dead_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dead_ff       <= dead_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff       <= req_tuser;
         key_start_ff <= req_start;
         key_end_ff   <= req_end;
         idx_ff       <= req_tdata[2*DW +: imit_pkg::IDX_W];
         ge_ff        <= ge_now;
         gt_ff        <= gt_now;
      end
      tail_ff       <= tail_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------- assertions ----------------
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_dead_only_collapse: assert property (@(posedge clock) disable iff (reset)
      (state_ff != imit_pkg::ST_COLLAPSE) |-> (dead_ff == '0))
      else $error("dead cells outside collapse");

   a_collapse_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imit_pkg::ST_COLLAPSE) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("collapse step did not drop one entry");

   a_load_only_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == imit_pkg::ST_DONE))
      else $error("result issued outside done state");

endmodule

`default_nettype wire
